[hdl/npq_pkg.sv]
// ----------------------------------------------------------------------------
// npq_pkg
// Shared types and constants of the nearest palette color quantizer.
// ----------------------------------------------------------------------------
package npq_pkg;

	localparam int PALETTE_DEPTH_DEF = 256;
	localparam int COLOR_W = 8;
	localparam int INDEX_W = 8;
	localparam int DIST_W = 18;
	localparam int COUNT_W = 9;

	localparam logic [1:0] REQ_LOAD  = 2'd0;
	localparam logic [1:0] REQ_QUANT = 2'd1;
	localparam logic [1:0] REQ_CLEAR = 2'd2;

	localparam logic [DIST_W-1:0] DIST_INIT = '1;

	typedef struct packed {
		logic [1:0]         req_type;
		logic [INDEX_W-1:0] entry_index;
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
	} in_item_t;

	typedef struct packed {
		logic [INDEX_W-1:0] best_index;
		logic [COLOR_W-1:0] out_red;
		logic [COLOR_W-1:0] out_green;
		logic [COLOR_W-1:0] out_blue;
		logic [DIST_W-1:0]  best_distance;
		logic [COUNT_W-1:0] colors_used;
	} out_item_t;

	typedef struct packed {
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
	} rgb_t;

	typedef struct packed {
		logic [1:0]         req_type;
		logic [INDEX_W-1:0] entry_index;
		rgb_t               pixel;
		logic [INDEX_W-1:0] best_index;
		logic [DIST_W-1:0]  best_distance;
		rgb_t               best_color;
	} chain_t;

endpackage

[hdl/nearest_palette_color_quantizer_top.sv]
// ----------------------------------------------------------------------------
// nearest_palette_color_quantizer_top
// An accepted request passes through the register of every cell in the chain and then the result register.
// Throughput: one transaction per cycle; the cell chain moves every cycle
// in which the result register is empty or its result is taken.
// Reset clears the usage map, the count and all valid flags; palette
// entries stay undefined until loaded.
// ----------------------------------------------------------------------------
module nearest_palette_color_quantizer_top #(
	parameter int PALETTE_DEPTH = npq_pkg::PALETTE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  npq_pkg::in_item_t  req_data,
	output logic               res_valid,
	input  logic               res_ready,
	output npq_pkg::out_item_t res_data
);
	import npq_pkg::*;

	logic                   advance;
	logic [PALETTE_DEPTH:0] stage_valid;
	chain_t                 stage_data [PALETTE_DEPTH+1];

	assign advance   = !res_valid || res_ready;
	assign req_ready = advance;

	assign stage_valid[0]              = req_valid;
	assign stage_data[0].req_type      = req_data.req_type;
	assign stage_data[0].entry_index   = req_data.entry_index;
	assign stage_data[0].pixel.red     = req_data.red;
	assign stage_data[0].pixel.green   = req_data.green;
	assign stage_data[0].pixel.blue    = req_data.blue;
	assign stage_data[0].best_index    = '0;
	assign stage_data[0].best_distance = DIST_INIT;
	assign stage_data[0].best_color    = '0;

	for (genvar i = 0; i < PALETTE_DEPTH; i++) begin : g_cell
		npq_cell #(
			.CELL_INDEX(i)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.advance    (advance),
			.prev_valid (stage_valid[i]),
			.prev_data  (stage_data[i]),
			.next_valid (stage_valid[i+1]),
			.next_data  (stage_data[i+1])
		);
	end

	npq_usage #(
		.PALETTE_DEPTH(PALETTE_DEPTH)
	) u_usage (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.last_valid (stage_valid[PALETTE_DEPTH]),
		.last_data  (stage_data[PALETTE_DEPTH]),
		.res_valid  (res_valid),
		.res_data   (res_data)
	);

endmodule

[hdl/npq_cell.sv]
// ----------------------------------------------------------------------------
// npq_cell
// One palette entry of the chain: loads its entry and folds its distance
// into the running best of the transaction passing through.
// ----------------------------------------------------------------------------
module npq_cell #(
	parameter int CELL_INDEX = 0
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            advance,
	input  logic            prev_valid,
	input  npq_pkg::chain_t prev_data,
	output logic            next_valid,
	output npq_pkg::chain_t next_data
);
	import npq_pkg::*;

	rgb_t               entry_q;
	logic               valid_q;
	chain_t             data_q;
	logic [COLOR_W-1:0] dr, dg, db;
	logic [15:0]        sq_r, sq_g, sq_b;
	logic [DIST_W-1:0]  cand_dist;
	chain_t             data_d;

	always_comb begin
		dr = (prev_data.pixel.red > entry_q.red) ? prev_data.pixel.red - entry_q.red
			: entry_q.red - prev_data.pixel.red;
		dg = (prev_data.pixel.green > entry_q.green) ? prev_data.pixel.green - entry_q.green
			: entry_q.green - prev_data.pixel.green;
		db = (prev_data.pixel.blue > entry_q.blue) ? prev_data.pixel.blue - entry_q.blue
			: entry_q.blue - prev_data.pixel.blue;
		sq_r = 16'(dr) * 16'(dr);
		sq_g = 16'(dg) * 16'(dg);
		sq_b = 16'(db) * 16'(db);
		cand_dist = DIST_W'(sq_r) + DIST_W'(sq_g) + DIST_W'(sq_b);
		data_d = prev_data;
		if (prev_data.req_type == REQ_QUANT && cand_dist < prev_data.best_distance) begin
			data_d.best_index    = INDEX_W'(CELL_INDEX);
			data_d.best_distance = cand_dist;
			data_d.best_color    = entry_q;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && prev_valid && prev_data.req_type == REQ_LOAD
			&& prev_data.entry_index == INDEX_W'(CELL_INDEX)) begin
			entry_q <= prev_data.pixel;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= prev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			data_q <= data_d;
		end
	end

	assign next_valid = valid_q;
	assign next_data  = data_q;

endmodule

[hdl/npq_usage.sv]
// ----------------------------------------------------------------------------
// npq_usage
// End of the chain: usage map, distinct color count and result register.
// ----------------------------------------------------------------------------
module npq_usage #(
	parameter int PALETTE_DEPTH = npq_pkg::PALETTE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               advance,
	input  logic               last_valid,
	input  npq_pkg::chain_t    last_data,
	output logic               res_valid,
	output npq_pkg::out_item_t res_data
);
	import npq_pkg::*;

	localparam int SEL_W = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

	logic [PALETTE_DEPTH-1:0] map_q, map_d;
	logic [COUNT_W-1:0]       total_q, total_d;
	logic [SEL_W-1:0]         sel;
	logic                     valid_q;
	logic                     quant_q;
	out_item_t                res_q;
	logic                     is_quant;

	assign sel      = last_data.best_index[SEL_W-1:0];
	assign is_quant = (last_data.req_type == REQ_QUANT);

	always_comb begin
		map_d   = map_q;
		total_d = total_q;
		if (last_valid) begin
			case (last_data.req_type)
				REQ_QUANT: begin
					if (!map_q[sel]) begin
						map_d[sel] = 1'b1;
						if (total_q < COUNT_W'(PALETTE_DEPTH)) begin
							total_d = total_q + COUNT_W'(1);
						end
					end
				end
				REQ_CLEAR: begin
					map_d   = '0;
					total_d = '0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_q   <= '0;
			total_q <= '0;
			valid_q <= 1'b0;
		end else if (advance) begin
			map_q   <= map_d;
			total_q <= total_d;
			valid_q <= last_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			quant_q                <= is_quant;
			res_q.best_index       <= is_quant ? last_data.best_index : '0;
			res_q.out_red          <= is_quant ? last_data.best_color.red : '0;
			res_q.out_green        <= is_quant ? last_data.best_color.green : '0;
			res_q.out_blue         <= is_quant ? last_data.best_color.blue : '0;
			res_q.best_distance    <= is_quant ? last_data.best_distance : '0;
			res_q.colors_used      <= total_d;
		end
	end

	assign res_valid = valid_q;
	assign res_data  = res_q;

`ifndef SYNTHESIS
	a_total_matches_map: assert property (@(posedge clk) disable iff (!arst_n)
		32'(total_q) == $countones(map_q))
		else $error("usage count differs from usage map");
	a_total_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= COUNT_W'(PALETTE_DEPTH))
		else $error("usage count above palette depth");
	a_nonquant_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !quant_q) |-> (res_q.best_index == '0 && res_q.best_distance == '0))
		else $error("non-quantize result carries a match");
	a_quant_index: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && quant_q) |-> (32'(res_q.best_index) < PALETTE_DEPTH))
		else $error("chosen index beyond palette depth");
	a_count_reported: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> (res_q.colors_used == total_q))
		else $error("reported count differs from usage count");
`endif

endmodule
